// ===== src/pdts_pkg.sv =====
// Shared types and codes of the priority/delay task scheduler.
// No dependencies.
package pdts_pkg;

	localparam int ID_W    = 8;
	localparam int PRIO_W  = 8;
	localparam int DELAY_W = 10;

	typedef enum logic [1:0] {
		REQ_ENQUEUE  = 2'd0,
		REQ_RERUN    = 2'd1,
		REQ_TICK     = 2'd2,
		REQ_DISPATCH = 2'd3
	} req_t;

	typedef enum logic {
		ST_IDLE,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic ins;
		logic pop;
	} rdy_op_t;

	typedef struct packed {
		logic ins;
		logic pop;
		logic tick;
	} dly_op_t;

endpackage

// ===== src/pdts_rdy_cell.sv =====
// One slot of the priority-sorted ready chain.
// Depends on pdts_pkg.
module pdts_rdy_cell
	import pdts_pkg::*;
(
	input  logic              clk,
	input  rdy_op_t           op,
	input  logic              occ,
	input  logic [ID_W-1:0]   new_id,
	input  logic [PRIO_W-1:0] new_prio,
	input  logic              prev_here,
	input  logic [ID_W-1:0]   prev_id,
	input  logic [PRIO_W-1:0] prev_prio,
	input  logic [ID_W-1:0]   next_id,
	input  logic [PRIO_W-1:0] next_prio,
	output logic              here,
	output logic [ID_W-1:0]   id,
	output logic [PRIO_W-1:0] prio
);

	logic [ID_W-1:0]   id_q;
	logic [PRIO_W-1:0] prio_q;

	// insertion point: first slot that is empty or holds a strictly larger priority
	assign here = !occ || (prio_q > new_prio);
	assign id   = id_q;
	assign prio = prio_q;

	always_ff @(posedge clk) begin
		if (op.pop) begin
			id_q   <= next_id;
			prio_q <= next_prio;
		end else if (op.ins) begin
			if (prev_here) begin
				id_q   <= prev_id;
				prio_q <= prev_prio;
			end else if (here) begin
				id_q   <= new_id;
				prio_q <= new_prio;
			end
		end
	end

endmodule

// ===== src/pdts_dly_cell.sv =====
// One slot of the delay chain, sorted by remaining ticks.
// Depends on pdts_pkg.
module pdts_dly_cell
	import pdts_pkg::*;
(
	input  logic               clk,
	input  dly_op_t            op,
	input  logic               occ,
	input  logic [ID_W-1:0]    new_id,
	input  logic [PRIO_W-1:0]  new_prio,
	input  logic [DELAY_W-1:0] new_left,
	input  logic               prev_here,
	input  logic [ID_W-1:0]    prev_id,
	input  logic [PRIO_W-1:0]  prev_prio,
	input  logic [DELAY_W-1:0] prev_left,
	input  logic [ID_W-1:0]    next_id,
	input  logic [PRIO_W-1:0]  next_prio,
	input  logic [DELAY_W-1:0] next_left,
	output logic               here,
	output logic [ID_W-1:0]    id,
	output logic [PRIO_W-1:0]  prio,
	output logic [DELAY_W-1:0] left
);

	logic [ID_W-1:0]    id_q;
	logic [PRIO_W-1:0]  prio_q;
	logic [DELAY_W-1:0] left_q;

	assign here = !occ || (left_q > new_left);
	assign id   = id_q;
	assign prio = prio_q;
	assign left = left_q;

	always_ff @(posedge clk) begin
		if (op.pop) begin
			id_q   <= next_id;
			prio_q <= next_prio;
			left_q <= next_left;
		end else if (op.ins) begin
			if (prev_here) begin
				id_q   <= prev_id;
				prio_q <= prev_prio;
				left_q <= prev_left;
			end else if (here) begin
				id_q   <= new_id;
				prio_q <= new_prio;
				left_q <= new_left;
			end
		end else if (op.tick && (left_q != '0)) begin
			left_q <= left_q - DELAY_W'(1);
		end
	end

endmodule

// ===== src/priority_delay_task_scheduler_unit.sv =====
// Top level: ready and delay cell chains plus request sequencing.
// Depends on pdts_pkg, pdts_rdy_cell, pdts_dly_cell.
//
//  channel | handshake            | word
//  --------+----------------------+----------------------------------------------
//  in      | in_valid / in_ready  | req_type, task_id, priority_req, delay_ticks
//  out     | out_valid / out_ready| task_valid, run_task_id, all_idle, overflow
//
// Enqueue, rerun and tick complete in the accepting cycle.
// Dispatch moves the expired delayed tasks into the ready chain one per cycle
// (at most QUEUE_DEPTH, only while it has room), then pops the ready head.
// One request at a time; a new word is taken once the result register is free
// or being emptied. Reset clears counts, current task and idle flag.
module priority_delay_task_scheduler_unit
	import pdts_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         req_type,
	input  logic [ID_W-1:0]    task_id,
	input  logic [PRIO_W-1:0]  priority_req,
	input  logic [DELAY_W-1:0] delay_ticks,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               task_valid,
	output logic [ID_W-1:0]    run_task_id,
	output logic               all_idle,
	output logic               overflow
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);

	state_t st_q, st_d;

	logic [CW-1:0]     rcount_q, dcount_q;
	logic [ID_W-1:0]   cur_id_q;
	logic [PRIO_W-1:0] cur_prio_q;
	logic              idle_q;

	logic              out_valid_q, task_valid_q, all_idle_q, overflow_q;
	logic [ID_W-1:0]   run_id_q;

	logic [ID_W-1:0]    r_id   [QUEUE_DEPTH];
	logic [PRIO_W-1:0]  r_prio [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] r_here, r_occ;
	logic [ID_W-1:0]    d_id   [QUEUE_DEPTH];
	logic [PRIO_W-1:0]  d_prio [QUEUE_DEPTH];
	logic [DELAY_W-1:0] d_left [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0] d_here, d_occ;

	rdy_op_t           r_op;
	dly_op_t           d_op;
	logic [ID_W-1:0]   r_new_id;
	logic [PRIO_W-1:0] r_new_prio;

	logic in_fire, r_full, d_full, drain_go, fin;
	logic is_enq, is_rerun0, is_rerun_d, is_tick;
	logic ovf_now, load_req, idle_new;
	logic [CW-1:0] rcount_after;

	assign in_ready = (st_q == ST_IDLE) && (!out_valid_q || out_ready);
	assign in_fire  = in_valid && in_ready;
	assign r_full   = rcount_q == CW'(QUEUE_DEPTH);
	assign d_full   = dcount_q == CW'(QUEUE_DEPTH);

	assign is_enq     = req_type == REQ_ENQUEUE;
	assign is_rerun0  = (req_type == REQ_RERUN) && (delay_ticks == '0);
	assign is_rerun_d = (req_type == REQ_RERUN) && (delay_ticks != '0);
	assign is_tick    = req_type == REQ_TICK;

	always_comb begin
		st_d = st_q;
		case (st_q)
			ST_IDLE:  if (in_fire && (req_type == REQ_DISPATCH)) st_d = ST_DRAIN;
			ST_DRAIN: if (fin) st_d = ST_IDLE;
			default:  st_d = ST_IDLE;
		endcase
	end

	always_comb begin
		drain_go   = 1'b0;
		fin        = 1'b0;
		case (st_q)
			ST_DRAIN: begin
				drain_go = (dcount_q != '0) && (d_left[0] == '0) && !r_full;
				fin      = !drain_go;
			end
			default: ;
		endcase
		r_op.ins   = (in_fire && (is_enq || is_rerun0) && !r_full) || drain_go;
		r_op.pop   = fin && (rcount_q != '0);
		d_op.ins   = in_fire && is_rerun_d && !d_full;
		d_op.pop   = drain_go;
		d_op.tick  = in_fire && is_tick;
		if (drain_go) begin
			r_new_id   = d_id[0];
			r_new_prio = d_prio[0];
		end else if (is_enq) begin
			r_new_id   = task_id;
			r_new_prio = priority_req;
		end else begin
			r_new_id   = cur_id_q;
			r_new_prio = cur_prio_q;
		end
		ovf_now  = ((is_enq || is_rerun0) && r_full) || (is_rerun_d && d_full);
		load_req = in_fire && (req_type != REQ_DISPATCH);
		rcount_after = rcount_q - CW'(r_op.pop);
		idle_new = idle_q || ((rcount_after == '0) && (dcount_q == '0));
	end

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			logic              rp_here, dp_here;
			logic [ID_W-1:0]   rp_id, rn_id, dp_id, dn_id;
			logic [PRIO_W-1:0] rp_prio, rn_prio, dp_prio, dn_prio;
			logic [DELAY_W-1:0] dp_left, dn_left;

			assign r_occ[gi] = rcount_q > CW'(gi);
			assign d_occ[gi] = dcount_q > CW'(gi);

			if (gi == 0) begin : g_head
				assign rp_here = 1'b0;
				assign rp_id   = r_id[gi];
				assign rp_prio = r_prio[gi];
				assign dp_here = 1'b0;
				assign dp_id   = d_id[gi];
				assign dp_prio = d_prio[gi];
				assign dp_left = d_left[gi];
			end else begin : g_body
				assign rp_here = r_here[gi-1];
				assign rp_id   = r_id[gi-1];
				assign rp_prio = r_prio[gi-1];
				assign dp_here = d_here[gi-1];
				assign dp_id   = d_id[gi-1];
				assign dp_prio = d_prio[gi-1];
				assign dp_left = d_left[gi-1];
			end

			if (gi == QUEUE_DEPTH - 1) begin : g_tail
				assign rn_id   = r_id[gi];
				assign rn_prio = r_prio[gi];
				assign dn_id   = d_id[gi];
				assign dn_prio = d_prio[gi];
				assign dn_left = d_left[gi];
			end else begin : g_mid
				assign rn_id   = r_id[gi+1];
				assign rn_prio = r_prio[gi+1];
				assign dn_id   = d_id[gi+1];
				assign dn_prio = d_prio[gi+1];
				assign dn_left = d_left[gi+1];
			end

			pdts_rdy_cell u_rdy (
				.clk       (clk),
				.op        (r_op),
				.occ       (r_occ[gi]),
				.new_id    (r_new_id),
				.new_prio  (r_new_prio),
				.prev_here (rp_here),
				.prev_id   (rp_id),
				.prev_prio (rp_prio),
				.next_id   (rn_id),
				.next_prio (rn_prio),
				.here      (r_here[gi]),
				.id        (r_id[gi]),
				.prio      (r_prio[gi])
			);

			pdts_dly_cell u_dly (
				.clk       (clk),
				.op        (d_op),
				.occ       (d_occ[gi]),
				.new_id    (cur_id_q),
				.new_prio  (cur_prio_q),
				.new_left  (delay_ticks),
				.prev_here (dp_here),
				.prev_id   (dp_id),
				.prev_prio (dp_prio),
				.prev_left (dp_left),
				.next_id   (dn_id),
				.next_prio (dn_prio),
				.next_left (dn_left),
				.here      (d_here[gi]),
				.id        (d_id[gi]),
				.prio      (d_prio[gi]),
				.left      (d_left[gi])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			rcount_q    <= '0;
			dcount_q    <= '0;
			cur_id_q    <= '0;
			cur_prio_q  <= '0;
			idle_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (r_op.ins && !r_op.pop)
				rcount_q <= rcount_q + CW'(1);
			else if (r_op.pop && !r_op.ins)
				rcount_q <= rcount_q - CW'(1);
			if (d_op.ins)
				dcount_q <= dcount_q + CW'(1);
			else if (d_op.pop)
				dcount_q <= dcount_q - CW'(1);
			if (r_op.pop) begin
				cur_id_q   <= r_id[0];
				cur_prio_q <= r_prio[0];
			end
			if (fin)
				idle_q <= idle_new;
			if (load_req || fin)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_req) begin
			task_valid_q <= 1'b0;
			run_id_q     <= '0;
			all_idle_q   <= idle_q;
			overflow_q   <= ovf_now;
		end else if (fin) begin
			task_valid_q <= r_op.pop;
			run_id_q     <= r_op.pop ? r_id[0] : '0;
			all_idle_q   <= idle_new;
			overflow_q   <= 1'b0;
		end
	end

	assign out_valid   = out_valid_q;
	assign task_valid  = task_valid_q;
	assign run_task_id = run_id_q;
	assign all_idle    = all_idle_q;
	assign overflow    = overflow_q;

endmodule

// ===== src/pdts_checker.sv =====
// Port-level checks on the scheduler, bound to the top level.
// Depends on pdts_pkg (widths) and priority_delay_task_scheduler_unit.
module pdts_checker
	import pdts_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input logic               task_valid,
	input logic [ID_W-1:0]    run_task_id,
	input logic               all_idle,
	input logic               overflow
);

	logic idle_seen_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idle_seen_q <= 1'b0;
		else if (out_valid && out_ready && all_idle)
			idle_seen_q <= 1'b1;
	end

	// stalled result word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(run_task_id) &&
		$stable(task_valid) && $stable(all_idle) && $stable(overflow))
		else $error("result word changed while stalled");

	// idle flag is sticky across delivered words
	a_idle_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && idle_seen_q |-> all_idle)
		else $error("idle flag dropped");

	// a dispatched task never comes with an overflow; no task means id zero
	a_word_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(task_valid && overflow) && (task_valid || run_task_id == '0))
		else $error("inconsistent result word");

	// new request only taken when the result register can take its word
	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |-> !out_valid || out_ready)
		else $error("request taken while result stalled");

endmodule

bind priority_delay_task_scheduler_unit pdts_checker u_pdts_checker (.*);

// ===== dv/tb_priority_delay_task_scheduler_unit.sv =====
// Testbench for priority_delay_task_scheduler_unit: random and directed requests,
// with scoreboard checks of every result word against a tracked model of the two queues.
// Depends on pdts_pkg and the scheduler RTL.
`timescale 1ns / 100ps

typedef struct packed {
	logic [pdts_pkg::ID_W-1:0]   id;
	logic [pdts_pkg::PRIO_W-1:0] prio;
} run_slot_t;

typedef struct packed {
	logic [pdts_pkg::ID_W-1:0]    id;
	logic [pdts_pkg::PRIO_W-1:0]  prio;
	logic [pdts_pkg::DELAY_W-1:0] left;
} sleep_slot_t;

typedef struct packed {
	logic                      task_valid;
	logic [pdts_pkg::ID_W-1:0] run_id;
	logic                      all_idle;
	logic                      overflow;
} outcome_t;

class sched_tracker;
	run_slot_t   run_queue[$];
	sleep_slot_t sleep_queue[$];
	outcome_t    due_outcomes[$];
	logic [pdts_pkg::ID_W-1:0]   cur_id;
	logic [pdts_pkg::PRIO_W-1:0] cur_prio;
	logic idle_seen;
	int   depth;
	int   failures;

	function new(int depth_i);
		depth     = depth_i;
		cur_id    = '0;
		cur_prio  = '0;
		idle_seen = 1'b0;
		failures  = 0;
	endfunction

	// stable insert: equal priorities keep arrival order
	function bit run_put(logic [7:0] id, logic [7:0] prio);
		run_slot_t s;
		int pos;
		if (run_queue.size() >= depth)
			return 0;
		pos = 0;
		while (pos < run_queue.size() && run_queue[pos].prio <= prio)
			pos++;
		s.id   = id;
		s.prio = prio;
		run_queue.insert(pos, s);
		return 1;
	endfunction

	function bit sleep_put(logic [7:0] id, logic [7:0] prio, logic [9:0] left);
		sleep_slot_t s;
		int pos;
		if (sleep_queue.size() >= depth)
			return 0;
		pos = 0;
		while (pos < sleep_queue.size() && sleep_queue[pos].left <= left)
			pos++;
		s.id   = id;
		s.prio = prio;
		s.left = left;
		sleep_queue.insert(pos, s);
		return 1;
	endfunction

	function void note_request(pdts_pkg::req_t kind, logic [7:0] id, logic [7:0] prio,
			logic [9:0] dly);
		outcome_t    o;
		sleep_slot_t s;
		o = '0;
		case (kind)
			pdts_pkg::REQ_ENQUEUE: begin
				if (!run_put(id, prio))
					o.overflow = 1'b1;
			end
			pdts_pkg::REQ_RERUN: begin
				if (dly == '0) begin
					if (!run_put(cur_id, cur_prio))
						o.overflow = 1'b1;
				end else if (!sleep_put(cur_id, cur_prio, dly)) begin
					o.overflow = 1'b1;
				end
			end
			pdts_pkg::REQ_TICK: begin
				for (int k = 0; k < sleep_queue.size(); k++) begin
					s = sleep_queue[k];
					if (s.left != '0)
						s.left = s.left - 1'b1;
					sleep_queue[k] = s;
				end
			end
			default: begin
				// expired sleepers move across until the run queue is full
				while (sleep_queue.size() > 0 && sleep_queue[0].left == '0 &&
						run_queue.size() < depth) begin
					void'(run_put(sleep_queue[0].id, sleep_queue[0].prio));
					sleep_queue.delete(0);
				end
				if (run_queue.size() > 0) begin
					cur_id       = run_queue[0].id;
					cur_prio     = run_queue[0].prio;
					o.task_valid = 1'b1;
					o.run_id     = cur_id;
					run_queue.delete(0);
				end
				if (run_queue.size() == 0 && sleep_queue.size() == 0)
					idle_seen = 1'b1;
			end
		endcase
		o.all_idle = idle_seen;
		due_outcomes.push_back(o);
	endfunction

	function void flag(string what, int unsigned exp_v, int unsigned got_v);
		failures++;
		if (failures <= 10)
			$display("%0t mismatch %s: expected %0d, got %0d", $time, what, exp_v, got_v);
	endfunction

	function void check_outcome(logic tv, logic [7:0] rid, logic idle, logic ovf);
		outcome_t o;
		if (due_outcomes.size() == 0) begin
			failures++;
			if (failures <= 10)
				$display("%0t result word with nothing outstanding", $time);
			return;
		end
		o = due_outcomes.pop_front();
		if (tv !== o.task_valid)
			flag("task_valid", 32'(o.task_valid), 32'(tv));
		if (rid !== o.run_id)
			flag("run_task_id", 32'(o.run_id), 32'(rid));
		if (idle !== o.all_idle)
			flag("all_idle", 32'(o.all_idle), 32'(idle));
		if (ovf !== o.overflow)
			flag("overflow", 32'(o.overflow), 32'(ovf));
	endfunction

	function void close_out();
		if (due_outcomes.size() != 0) begin
			failures++;
			if (failures <= 10)
				$display("%0d result words never arrived", due_outcomes.size());
		end
	endfunction
endclass

module tb_priority_delay_task_scheduler_unit;
	import pdts_pkg::*;

	localparam int QDEPTH      = 16;
	localparam int QUIET_LIMIT = 5000;
	localparam int HOLD_CYCLES = 300;
	localparam int MODE_FILL   = 0;
	localparam int MODE_PARK   = 1;
	localparam int MODE_DELAY  = 2;
	localparam int MODE_DRAIN  = 3;
	localparam int MODE_MIX    = 4;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	req_t               req_type;
	logic [ID_W-1:0]    task_id;
	logic [PRIO_W-1:0]  priority_req;
	logic [DELAY_W-1:0] delay_ticks;
	logic               out_valid;
	logic               out_ready;
	logic               task_valid;
	logic [ID_W-1:0]    run_task_id;
	logic               all_idle;
	logic               overflow;

	int send_idle_pct;
	int recv_stall_pct;
	bit hold_request;
	int quiet_cycles;
	int age_ticks;

	sched_tracker board = new(QDEPTH);

	priority_delay_task_scheduler_unit #(
		.QUEUE_DEPTH(QDEPTH)
	) u_dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.req_type    (req_type),
		.task_id     (task_id),
		.priority_req(priority_req),
		.delay_ticks (delay_ticks),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.task_valid  (task_valid),
		.run_task_id (run_task_id),
		.all_idle    (all_idle),
		.overflow    (overflow)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				board.note_request(req_type, task_id, priority_req, delay_ticks);
			if (out_valid && out_ready)
				board.check_outcome(task_valid, run_task_id, all_idle, overflow);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver: random stalls, plus one long hold-off on request
	initial begin
		out_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else if (recv_stall_pct == 0) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	task automatic offer_word(input req_t kind, input logic [7:0] id, input logic [7:0] prio,
			input logic [9:0] dly);
		int gap;
		gap = 0;
		while (send_idle_pct > 0 && gap < 40 && $urandom_range(99) < send_idle_pct)
			gap++;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid     <= 1'b1;
		req_type     <= kind;
		task_id      <= id;
		priority_req <= prio;
		delay_ticks  <= dly;
		do @(posedge clk); while (!in_ready);
	endtask

	// bursts of one flavour each, so the queues fill, overflow and drain
	task automatic run_random(input int count);
		int mode, burst, roll, enq_lim, rerun_lim, tick_lim;
		logic [7:0] prio;
		logic [9:0] dly;
		req_t kind;
		while (count > 0) begin
			mode  = $urandom_range(MODE_MIX);
			burst = $urandom_range(40, 10);
			case (mode)
				MODE_FILL:  begin enq_lim = 70; rerun_lim = 80; tick_lim = 88; end
				MODE_PARK:  begin enq_lim = 15; rerun_lim = 85; tick_lim = 90; end
				MODE_DELAY: begin enq_lim = 15; rerun_lim = 55; tick_lim = 80; end
				MODE_DRAIN: begin enq_lim = 10; rerun_lim = 15; tick_lim = 35; end
				default:    begin enq_lim = 25; rerun_lim = 50; tick_lim = 75; end
			endcase
			while (burst > 0 && count > 0) begin
				roll = $urandom_range(99);
				if (roll < enq_lim)
					kind = REQ_ENQUEUE;
				else if (roll < rerun_lim)
					kind = REQ_RERUN;
				else if (roll < tick_lim)
					kind = REQ_TICK;
				else
					kind = REQ_DISPATCH;
				// narrow priorities give plenty of ties
				prio = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) :
					8'($urandom_range(7));
				roll = $urandom_range(99);
				if (roll < 2)
					dly = 10'($urandom_range(60, 31));
				else if (mode == MODE_PARK)
					dly = 10'($urandom_range(30, 1));
				else if (roll < 25)
					dly = '0;
				else
					dly = 10'($urandom_range(4, 1));
				offer_word(kind, 8'($urandom_range(255)), prio, dly);
				burst--;
				count--;
			end
		end
	endtask

	initial begin
		arst_n         <= 1'b0;
		in_valid       <= 1'b0;
		req_type       <= REQ_ENQUEUE;
		task_id        <= '0;
		priority_req   <= '0;
		delay_ticks    <= '0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_request   = 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// rerun before any dispatch uses the reset task
		offer_word(REQ_RERUN, 8'd9, 8'd9, 10'd0);
		offer_word(REQ_RERUN, 8'd9, 8'd9, 10'd90);
		offer_word(REQ_DISPATCH, 8'd0, 8'd0, 10'd0);
		offer_word(REQ_DISPATCH, 8'd0, 8'd0, 10'd0);
		offer_word(REQ_ENQUEUE, 8'd255, 8'd255, 10'd0);
		offer_word(REQ_ENQUEUE, 8'd0, 8'd255, 10'd1023);
		offer_word(REQ_ENQUEUE, 8'd170, 8'd0, 10'd0);
		offer_word(REQ_ENQUEUE, 8'd85, 8'd0, 10'd0);
		offer_word(REQ_ENQUEUE, 8'd1, 8'd128, 10'd0);
		offer_word(REQ_DISPATCH, 8'd0, 8'd0, 10'd0);
		offer_word(REQ_RERUN, 8'd0, 8'd0, 10'd2);
		offer_word(REQ_RERUN, 8'd0, 8'd0, 10'd2);
		offer_word(REQ_RERUN, 8'd0, 8'd0, 10'd1);
		offer_word(REQ_TICK, 8'd0, 8'd0, 10'd0);
		offer_word(REQ_TICK, 8'd0, 8'd0, 10'd0);
		offer_word(REQ_TICK, 8'd0, 8'd0, 10'd0);
		offer_word(REQ_DISPATCH, 8'd0, 8'd0, 10'd0);
		offer_word(REQ_RERUN, 8'd0, 8'd0, 10'd0);
		offer_word(REQ_DISPATCH, 8'd0, 8'd0, 10'd0);
		offer_word(REQ_DISPATCH, 8'd0, 8'd0, 10'd0);
		offer_word(REQ_ENQUEUE, 8'd77, 8'd77, 10'd512);

		// receiver holds off while the sender keeps offering words
		hold_request = 1'b1;
		run_random(150);
		send_idle_pct = 77;
		run_random(150);
		send_idle_pct  = 0;
		recv_stall_pct = 77;
		run_random(150);
		send_idle_pct  = 8;
		recv_stall_pct = 8;
		run_random(150);

		// age every sleeper out, then empty both queues so the idle flag rises
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		in_valid <= 1'b0;
		@(posedge clk);
		age_ticks = (board.sleep_queue.size() > 0) ? int'(board.sleep_queue[$].left) : 0;
		repeat (age_ticks)
			offer_word(REQ_TICK, 8'($urandom_range(255)), 8'($urandom_range(255)), 10'd0);
		repeat (40) offer_word(REQ_DISPATCH, 8'd0, 8'd0, 10'd0);

		// delays above the usual range stay parked behind a short one
		offer_word(REQ_RERUN, 8'd0, 8'd0, 10'd1023);
		offer_word(REQ_RERUN, 8'd0, 8'd0, 10'd1000);
		offer_word(REQ_RERUN, 8'd0, 8'd0, 10'd999);
		offer_word(REQ_RERUN, 8'd0, 8'd0, 10'd2);
		offer_word(REQ_TICK, 8'd0, 8'd0, 10'd0);
		offer_word(REQ_TICK, 8'd0, 8'd0, 10'd0);
		offer_word(REQ_DISPATCH, 8'd0, 8'd0, 10'd0);
		offer_word(REQ_DISPATCH, 8'd0, 8'd0, 10'd0);
		in_valid <= 1'b0;

		while (board.due_outcomes.size() != 0)
			@(posedge clk);
		repeat (2 * QDEPTH + 8) @(posedge clk);
		board.close_out();
		if (board.failures == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
